// ----- rtl/lzw_pkg.sv -----
// Package for the LZW byte compressor: code-space constants, widths and the
// result record type. Used by rtl/lzw_byte_compressor.sv; depends on nothing.
`timescale 1ns / 1ps

package lzw_pkg;

    // Code space and alphabet.
    localparam int NUM_CODES  = 4096;
    localparam int SYMBOLS    = 256;
    localparam int SYM_W      = 8;
    localparam int CODE_W     = 12;
    localparam int NF_W       = CODE_W + 1;
    localparam int KEY_W      = CODE_W + SYM_W;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    // Output queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CNT_W      = 3;

    // One emitted code and its end-of-chunk mark.
    typedef struct packed {
        logic              last;
        logic [CODE_W-1:0] code;
    } t_res;

endpackage

// ----- rtl/lzw_byte_compressor.sv -----
// LZW compressor over a byte stream split into chunks, with a 1M-entry
// forward dictionary and a 4K-entry reverse table in synchronous memories.
// Depends on rtl/lzw_pkg.sv.
// A byte with a pending prefix reads the forward dictionary in ST_FWD, then the reverse table
// confirms the entry and the byte is decided in ST_REV; its codes are registered into the output queue.
// A new byte can be taken while the previous one is decided in ST_REV, but not in ST_FWD; the beat
// after a chunk's last byte waits for ST_IDLE, and the input stalls while the output queue would
// hold more than two beats.
// Reset: synchronous, active low; no clearing pass, since an entry counts only when its
// code lies below the allocation counter and the reverse table maps it back to its key.
`timescale 1ns / 1ps

module lzw_byte_compressor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream: tdata = in_byte[7:0]; tlast = last_byte.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [lzw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tlast,
    // Output stream: tdata = code[11:0], zeros[15:12]; tlast = last_code.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [lzw_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FWD  = 2'd1;
    localparam logic [1:0] ST_REV  = 2'd2;

    localparam int CW = lzw_pkg::CODE_W;
    localparam int SW = lzw_pkg::SYM_W;
    localparam int KW = lzw_pkg::KEY_W;

    // Dictionary memories.
    logic [CW-1:0] r_fwd_mem [lzw_pkg::NUM_CODES * lzw_pkg::SYMBOLS];
    logic [KW-1:0] r_rev_mem [lzw_pkg::NUM_CODES];
    logic [CW-1:0] r_fwd_q;
    logic [KW-1:0] r_rev_q;

    // Control and item registers.
    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_prefix, n_prefix;
    logic                    r_have, n_have;
    logic [lzw_pkg::NF_W-1:0] r_nf, n_nf;
    logic [SW-1:0]           r_byte, n_byte;
    logic                    r_last, n_last;
    logic [CW-1:0]           r_code, n_code;
    logic                    r_byp, n_byp;
    logic [CW-1:0]           r_byp_code, n_byp_code;

    // Output queue.
    lzw_pkg::t_res              r_fifo [lzw_pkg::FIFO_DEPTH];
    logic [lzw_pkg::FIFO_AW-1:0] r_wptr, r_rptr;
    logic [lzw_pkg::CNT_W-1:0]   r_count, n_count;

    logic            accept;
    logic            hit;
    logic            fwd_we;
    logic [KW-1:0]   cur_key;
    logic [KW-1:0]   fwd_raddr;
    logic [CW-1:0]   rev_raddr;
    logic            push0_v, push1_v;
    lzw_pkg::t_res   push0, push1;
    logic [1:0]      npush;
    logic            pop;

    assign cur_key = {r_prefix, r_byte};

    // Entry confirmation: code allocated in this chunk and mapped back to the key.
    assign hit = (r_code >= CW'(lzw_pkg::SYMBOLS))
              && ({1'b0, r_code} < r_nf)
              && (r_rev_q == cur_key);

    // Decision, acceptance and memory addressing.
    always_comb begin
        n_state    = r_state;
        n_prefix   = r_prefix;
        n_have     = r_have;
        n_nf       = r_nf;
        n_byte     = r_byte;
        n_last     = r_last;
        n_code     = r_code;
        n_byp      = 1'b0;
        n_byp_code = r_nf[CW-1:0];
        push0_v    = 1'b0;
        push1_v    = 1'b0;
        push0      = '0;
        push1      = '0;
        fwd_we     = 1'b0;
        s_axis_tready = 1'b0;
        fwd_raddr  = cur_key;
        rev_raddr  = r_code;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = (r_count <= lzw_pkg::CNT_W'(2));
            end
            ST_FWD: begin
                // Forward data is here; a same-cycle write is taken from the bypass.
                if (r_byp) begin
                    n_code = r_byp_code;
                end else begin
                    n_code = r_fwd_q;
                end
                rev_raddr = n_code;
                n_state   = ST_REV;
            end
            ST_REV: begin
                n_state = ST_IDLE;
                if (hit) begin
                    n_prefix = r_code;
                    if (r_last) begin
                        push0_v = 1'b1;
                        push0   = '{last: 1'b1, code: r_code};
                    end
                end else begin
                    push0_v = 1'b1;
                    push0   = '{last: 1'b0, code: r_prefix};
                    if (r_nf < lzw_pkg::NF_W'(lzw_pkg::NUM_CODES)) begin
                        fwd_we = 1'b1;
                        n_nf   = r_nf + 1'b1;
                    end
                    n_prefix = {{(CW-SW){1'b0}}, r_byte};
                    if (r_last) begin
                        push1_v = 1'b1;
                        push1   = '{last: 1'b1, code: {{(CW-SW){1'b0}}, r_byte}};
                    end
                end
                // End of chunk: forget the prefix and restart allocation.
                if (r_last) begin
                    n_have   = 1'b0;
                    n_prefix = '0;
                    n_nf     = lzw_pkg::NF_W'(lzw_pkg::SYMBOLS);
                end
                s_axis_tready = n_have
                    && ((r_count + lzw_pkg::CNT_W'(push0_v) + lzw_pkg::CNT_W'(push1_v))
                        <= lzw_pkg::CNT_W'(2));
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        accept = s_axis_tvalid && s_axis_tready;

        // New beat: look it up, or make it the first prefix of the chunk (emitted at once if it is also the last).
        if (accept) begin
            n_byte = s_axis_tdata[SW-1:0];
            n_last = s_axis_tlast;
            if (n_have) begin
                fwd_raddr  = {n_prefix, s_axis_tdata[SW-1:0]};
                n_state    = ST_FWD;
                n_byp      = fwd_we && (fwd_raddr == cur_key);
            end else begin
                n_have   = 1'b1;
                n_prefix = {{(CW-SW){1'b0}}, s_axis_tdata[SW-1:0]};
                if (s_axis_tlast) begin
                    push0_v  = 1'b1;
                    push0    = '{last: 1'b1, code: {{(CW-SW){1'b0}}, s_axis_tdata[SW-1:0]}};
                    n_have   = 1'b0;
                    n_prefix = '0;
                end
            end
        end
    end

    assign npush = {1'b0, push0_v} + {1'b0, push1_v};
    assign pop   = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_count = r_count + lzw_pkg::CNT_W'(npush) - lzw_pkg::CNT_W'(pop);
    end

    // Forward dictionary: registered read, written on allocation.
    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_fwd_mem[cur_key] <= r_nf[CW-1:0];
        end
        r_fwd_q <= r_fwd_mem[fwd_raddr];
    end

    // Reverse table: code to key, written together with the forward entry.
    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_rev_mem[r_nf[CW-1:0]] <= cur_key;
        end
        r_rev_q <= r_rev_mem[rev_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prefix <= '0;
            r_have   <= 1'b0;
            r_nf     <= lzw_pkg::NF_W'(lzw_pkg::SYMBOLS);
            r_byp    <= 1'b0;
            r_count  <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
        end else begin
            r_state  <= n_state;
            r_prefix <= n_prefix;
            r_have   <= n_have;
            r_nf     <= n_nf;
            r_byp    <= n_byp;
            r_count  <= n_count;
            r_wptr   <= r_wptr + lzw_pkg::FIFO_AW'(npush);
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_code     <= n_code;
        r_byp_code <= n_byp_code;
    end

    // Output queue storage: up to two beats written per cycle.
    always_ff @(posedge i_clk) begin
        if (push0_v) begin
            r_fifo[r_wptr] <= push0;
        end
        if (push1_v) begin
            r_fifo[r_wptr + 1'b1] <= push1;
        end
    end

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {{(lzw_pkg::M_TDATA_W-CW){1'b0}}, r_fifo[r_rptr].code};
    assign m_axis_tlast  = r_fifo[r_rptr].last;

    // Checks on the control logic.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lzw_pkg::CNT_W'(lzw_pkg::FIFO_DEPTH))
        else $error("output queue overflow");

    a_fwd_then_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FWD) |=> (r_state == ST_REV))
        else $error("forward read not followed by confirmation");

    a_no_accept_in_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FWD) |-> !s_axis_tready)
        else $error("beat taken while a lookup is in flight");

    a_nf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nf >= lzw_pkg::NF_W'(lzw_pkg::SYMBOLS))
        && (r_nf <= lzw_pkg::NF_W'(lzw_pkg::NUM_CODES)))
        else $error("allocation counter out of range");

    a_fresh_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_nf == lzw_pkg::NF_W'(lzw_pkg::SYMBOLS)))
        else $error("entries allocated without a pending prefix");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for lzw_byte_compressor: byte chunks in, 12-bit LZW codes out.
// Depends on rtl/lzw_pkg.sv and rtl/lzw_byte_compressor.sv.
// A predictor keeps its own dictionary and queues the codes that each accepted byte should emit.
`timescale 1ns / 1ps

module testbench;

    // Tracks the dictionary state of the current chunk and the codes still owed by the block.
    class t_code_tracker;
        bit [lzw_pkg::CODE_W-1:0] dict [bit [lzw_pkg::KEY_W-1:0]];
        bit [lzw_pkg::CODE_W-1:0] prefix;
        bit                       have_prefix;
        bit [lzw_pkg::NF_W-1:0]   next_free;
        lzw_pkg::t_res            codes_due[$];
        int unsigned              taken;
        int unsigned              mismatches;

        function new();
            clear_chunk();
            taken      = 0;
            mismatches = 0;
        endfunction

        function void clear_chunk();
            dict.delete();
            prefix      = '0;
            have_prefix = 1'b0;
            next_free   = lzw_pkg::NF_W'(lzw_pkg::SYMBOLS);
        endfunction

        // Prints one line per mismatch and counts it.
        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function void push_code(bit [lzw_pkg::CODE_W-1:0] c, bit lst);
            lzw_pkg::t_res r;
            r.code = c;
            r.last = lst;
            codes_due.push_back(r);
        endfunction

        // One accepted input beat: advance the prefix and queue the codes it releases.
        function void take_byte(bit [lzw_pkg::SYM_W-1:0] in_byte, bit lst);
            bit [lzw_pkg::KEY_W-1:0] key;
            taken++;
            if (!have_prefix) begin
                prefix      = lzw_pkg::CODE_W'(in_byte);
                have_prefix = 1'b1;
            end else begin
                key = {prefix, in_byte};
                if (dict.exists(key)) begin
                    prefix = dict[key];
                end else begin
                    push_code(prefix, 1'b0);
                    // Once the code space is used up the dictionary stays as it is.
                    if (next_free < lzw_pkg::NF_W'(lzw_pkg::NUM_CODES)) begin
                        dict[key] = next_free[lzw_pkg::CODE_W-1:0];
                        next_free++;
                    end
                    prefix = lzw_pkg::CODE_W'(in_byte);
                end
            end
            // The chunk's last byte flushes the prefix and starts a fresh dictionary.
            if (lst) begin
                push_code(prefix, 1'b1);
                clear_chunk();
            end
        endfunction

        // One accepted output beat: compare against the oldest queued code.
        task match_code(logic [lzw_pkg::M_TDATA_W-1:0] data, logic lst);
            lzw_pkg::t_res want;
            if (codes_due.size() == 0) begin
                report($sformatf("unexpected code %0d last %b", data, lst));
                return;
            end
            want = codes_due.pop_front();
            if (data[lzw_pkg::CODE_W-1:0] !== want.code)
                report($sformatf("code %0d, want %0d", data[lzw_pkg::CODE_W-1:0], want.code));
            if (data[lzw_pkg::M_TDATA_W-1:lzw_pkg::CODE_W] !== '0)
                report($sformatf("tdata padding %h not zero",
                                 data[lzw_pkg::M_TDATA_W-1:lzw_pkg::CODE_W]));
            if (lst !== want.last)
                report($sformatf("tlast %b, want %b (code %0d)", lst, want.last, want.code));
        endtask

        task finish();
            if (codes_due.size() != 0)
                report($sformatf("%0d codes never came out", codes_due.size()));
        endtask
    endclass

    typedef enum {CHUNK_NARROW, CHUNK_WIDE, CHUNK_RUNS} t_chunk_kind;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lzw_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;    // in_byte[7:0]
    logic                            s_axis_tlast  = 1'b0;  // last_byte
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lzw_pkg::M_TDATA_W-1:0]   m_axis_tdata;          // code[11:0], zeros[15:12]
    logic                            m_axis_tlast;          // last_code

    logic                            calm          = 1'b0;  // no idling on either side
    logic                            hold_off      = 1'b0;  // long receiver stall
    int unsigned                     stall_left    = 0;

    t_code_tracker sb = new();

    lzw_byte_compressor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones; none while calm.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one byte and returns at the edge where it is accepted.
    task automatic send_byte(input logic [lzw_pkg::SYM_W-1:0] b, input logic lst);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_byte(b, lst);
    endtask

    // One chunk of random content whose last beat carries tlast.
    task automatic send_chunk(input t_chunk_kind kind, input int unsigned len);
        logic [lzw_pkg::SYM_W-1:0] base;
        logic [lzw_pkg::SYM_W-1:0] b;
        logic [lzw_pkg::SYM_W-1:0] pat [4];
        int unsigned               span;
        int unsigned               plen;
        base = lzw_pkg::SYM_W'($urandom);
        span = (3 << $urandom_range(0, 2)) - 1;   // 3, 6 or 12 distinct offsets
        plen = $urandom_range(1, 4);
        for (int k = 0; k < 4; k++) pat[k] = lzw_pkg::SYM_W'($urandom);
        for (int unsigned i = 0; i < len; i++) begin
            case (kind)
                CHUNK_NARROW: b = base + lzw_pkg::SYM_W'($urandom_range(0, span));
                CHUNK_RUNS: begin
                    b = pat[i % plen];
                    if ($urandom_range(0, 19) == 0) b = lzw_pkg::SYM_W'($urandom);
                end
                default: b = lzw_pkg::SYM_W'($urandom);
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Receiver: checks each output beat and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.match_code(m_axis_tdata, m_axis_tlast);
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_off || !i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
            stall_left    <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Long receiver hold-off while the sender keeps offering, so the output queue fills.
    initial begin
        while (sb.taken < 300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (500) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Reset, directed chunks, random chunks, then drain and verdict.
    initial begin
        int unsigned sent;
        int unsigned len;
        int unsigned r;
        bit          big_done;
        t_chunk_kind kind;
        sent     = 0;
        big_done = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-byte chunks at both ends of the byte range.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Mismatch followed by the last byte: two codes from one beat.
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        // Repeated byte: matches extend the prefix into new codes.
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Alternating pair, ending on a matched prefix.
        for (int i = 0; i < 7; i++) send_byte((i % 2) ? 8'hFF : 8'h00, i == 6);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);

        while (sent < 2000) begin
            // One long chunk that drives the codes far above the byte range.
            if (!big_done && sent >= 400) begin
                big_done = 1'b1;
                send_chunk(CHUNK_WIDE, 1200);
                sent += 1200;
            end
            calm <= ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 9);
            kind = (r < 4) ? CHUNK_NARROW : (r < 7) ? CHUNK_RUNS : CHUNK_WIDE;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 120);
            send_chunk(kind, len);
            sent += len;
        end
        s_axis_tvalid <= 1'b0;
        calm          <= 1'b0;

        while (sb.codes_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.finish();
        if (sb.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #50_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lzw_pkg.sv
rtl/lzw_byte_compressor.sv
dv/testbench.sv
